@@ rtl/core/ioc_pkg.sv @@
// ----------------------------------------------------------------------------
// ioc_pkg: shared types and constants
// Widths, limits and the job record passed from the histogram front end
// to the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ioc_pkg;

	localparam int ALPHABET    = 26;
	localparam int MAX_LEN     = 255;
	localparam int LETTER_W    = 5;
	localparam int CNT_W       = 8;
	localparam int SUM_W       = 16;
	localparam int FRAC_W      = 17;
	localparam int STEP_W      = $clog2(FRAC_W);
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one finished message, waiting for its division
	typedef struct packed {
		logic [SUM_W-1:0] pair_sum;
		logic [CNT_W-1:0] count;
		logic             too_long;
	} ioc_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} ioc_back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/ioc_front.sv @@
// ----------------------------------------------------------------------------
// ioc_front: letter histogram
// Counts letters per bin, keeps the count and the running sum of f(f-1),
// and hands a job record to the queue on the last letter of a message.
// ----------------------------------------------------------------------------
`default_nettype none

module ioc_front import ioc_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                accept,
	input  wire [LETTER_W-1:0] letter,
	input  wire                last_letter,
	output logic               push,
	output ioc_job_t           job
);

	logic [CNT_W-1:0] bins_q [ALPHABET];
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic             overflow_q;

	logic             in_range;
	logic             full;
	logic             hit;
	logic [CNT_W-1:0] old_bin;
	logic [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0] count_new;
	logic             overflow_new;

	assign in_range = letter < LETTER_W'(ALPHABET);
	assign full     = count_q == CNT_W'(MAX_LEN);
	assign hit      = accept && in_range && !full;
	assign old_bin  = in_range ? bins_q[letter] : '0;

	// f(f-1) grows by 2*f_old on each hit
	assign sum_new      = sum_q + SUM_W'({old_bin, 1'b0});
	assign count_new    = count_q + CNT_W'(1);
	assign overflow_new = overflow_q | (accept && in_range && full);

	assign push          = accept && last_letter;
	assign job.pair_sum  = hit ? sum_new : sum_q;
	assign job.count     = hit ? count_new : count_q;
	assign job.too_long  = overflow_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET; i++) bins_q[i] <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			overflow_q <= 1'b0;
		end else if (push) begin
			// message done: whole store clears at once
			for (int i = 0; i < ALPHABET; i++) bins_q[i] <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			if (hit) begin
				bins_q[letter] <= old_bin + CNT_W'(1);
				count_q        <= count_new;
				sum_q          <= sum_new;
			end
			overflow_q <= overflow_new;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ioc_queue.sv @@
// ----------------------------------------------------------------------------
// ioc_queue: job queue
// Small FIFO of finished messages between histogram and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ioc_queue import ioc_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push,
	input  ioc_job_t  push_job,
	input  wire       pop,
	output ioc_job_t  head,
	output logic      empty,
	output logic      full
);

	ioc_job_t          slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	assign empty = fill_q == '0;
	assign full  = fill_q == QCNT_W'(QUEUE_DEPTH);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QCNT_W'(1);
				2'b01:   fill_q <= fill_q - QCNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ioc_back.sv @@
// ----------------------------------------------------------------------------
// ioc_back: IC divider
// Pops a job, forms n(n-1), then restoring division one quotient bit per
// cycle to get floor(sum * 2^16 / (n(n-1))); presents the result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ioc_back import ioc_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  ioc_job_t           head,
	input  wire                empty,
	output logic               pop,
	output logic               done,
	output logic [FRAC_W-1:0]  ic_fraction,
	output logic [CNT_W-1:0]   letter_count,
	output logic               too_long
);

	ioc_back_state_t   state_q, state_nx;

	ioc_job_t          job_q;
	logic [SUM_W-1:0]  den_q;
	logic [FRAC_W-1:0] rem_q;
	logic [FRAC_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;

	logic              short_msg;
	logic              last_step;
	logic [FRAC_W-1:0] shifted;
	logic              ge;

	assign short_msg = job_q.count < CNT_W'(2);
	assign last_step = step_q == STEP_W'(FRAC_W - 1);

	// first step compares sum itself (quotient bit 16), later ones shift in a zero
	assign shifted = (step_q == '0) ? rem_q : {rem_q[FRAC_W-2:0], 1'b0};
	assign ge      = shifted >= FRAC_W'(den_q);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: if (!empty) state_nx = BK_MUL;
			BK_MUL:  state_nx = short_msg ? BK_OUT : BK_DIV;
			BK_DIV:  if (last_step) state_nx = BK_OUT;
			BK_OUT:  state_nx = BK_IDLE;
			default: state_nx = BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		done = 1'b0;
		unique case (state_q)
			BK_IDLE: pop  = !empty;
			BK_OUT:  done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else         state_q <= state_nx;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) job_q <= head;
			end
			BK_MUL: begin
				den_q  <= SUM_W'(job_q.count) * SUM_W'(job_q.count - CNT_W'(1));
				rem_q  <= FRAC_W'(job_q.pair_sum);
				quo_q  <= '0;
				step_q <= '0;
			end
			BK_DIV: begin
				rem_q  <= ge ? shifted - FRAC_W'(den_q) : shifted;
				quo_q  <= {quo_q[FRAC_W-2:0], ge};
				step_q <= step_q + STEP_W'(1);
			end
			default: ;
		endcase
	end

	assign ic_fraction  = short_msg ? '0 : quo_q;
	assign letter_count = job_q.count;
	assign too_long     = job_q.too_long;

endmodule

`default_nettype wire

@@ rtl/core/index_of_coincidence.sv @@
// ----------------------------------------------------------------------------
// index_of_coincidence: index of coincidence over a letter stream
// Histograms decoded letters per message and reports sum f(f-1) / (n(n-1))
// as an unsigned Q1.16 fraction for each message.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ----------------------------------------
//  input     start & !busy           letter[4:0], last_letter
//  result    done (one-cycle pulse)  ic_fraction[16:0], letter_count[7:0],
//                                    too_long
//
//  One letter per cycle while busy is low: the histogram reads, adds and
//  writes a bin in the same cycle. done follows the last accepted letter
//  through queue pop, n(n-1) multiply, 17 divider steps and output state;
//  a message under two letters skips the divide. A job that finds the
//  divider occupied waits in the queue first. A two-entry job queue lets
//  the next message stream in during the division; busy is high only while
//  that queue is full. Reset clears histogram, queue pointers and FSM at
//  once, no sweep. The receiver cannot stall: done is a one-cycle strobe.
//
`default_nettype none

module index_of_coincidence import ioc_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire [LETTER_W-1:0] letter,
	input  wire                last_letter,
	output logic               done,
	output logic [FRAC_W-1:0]  ic_fraction,
	output logic [CNT_W-1:0]   letter_count,
	output logic               too_long
);

	logic     accept;
	logic     push;
	ioc_job_t push_job;
	ioc_job_t head;
	logic     pop;
	logic     empty;
	logic     full;

	// full queue blocks requests; a request may carry the last letter
	assign busy   = full;
	assign accept = start && !busy;

	ioc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.letter      (letter),
		.last_letter (last_letter),
		.push        (push),
		.job         (push_job)
	);

	ioc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	ioc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.done         (done),
		.ic_fraction  (ic_fraction),
		.letter_count (letter_count),
		.too_long     (too_long)
	);

endmodule

`default_nettype wire

@@ rtl/core/ioc_checker.sv @@
// ----------------------------------------------------------------------------
// ioc_checker: port-level checks
// Watches the top-level ports and flags impossible results.
// ----------------------------------------------------------------------------
`default_nettype none

module ioc_checker import ioc_pkg::*; (
	input wire                clk,
	input wire                arst_n,
	input wire                done,
	input wire [FRAC_W-1:0]   ic_fraction,
	input wire [CNT_W-1:0]    letter_count,
	input wire                too_long
);

	// the divider returns to idle after each result, so strobes never touch
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high two cycles in a row");

	// fraction never exceeds one
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!ic_fraction[FRAC_W-1] || ic_fraction[FRAC_W-2:0] == '0))
		else $error("ic_fraction above 1.0");

	// fewer than two letters means no pairs
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && letter_count < CNT_W'(2)) |-> ic_fraction == '0)
		else $error("nonzero IC for short message");

	// a flagged overflow means the message filled up
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && too_long) |-> letter_count == CNT_W'(MAX_LEN))
		else $error("too_long without full count");

endmodule

bind index_of_coincidence ioc_checker u_ioc_checker (.*);

`default_nettype wire
